// ===== rtl/sdsm_pkg.sv =====
// Package: shared constants, types and the merge rule decode for the doc-id set merge.
`default_nettype none
package sdsm_pkg;

	localparam int ID_W = 31;

	// input item kinds
	localparam logic [1:0] KIND_LOAD_A = 2'd0;
	localparam logic [1:0] KIND_LOAD_B = 2'd1;
	localparam logic [1:0] KIND_RUN    = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_OPERATION  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_NEG  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_NEG = 2'd2;
	localparam int CFG_DATA_W = 1;

	// operator codes
	localparam logic OP_AND = 1'b0;

	// walk modes
	localparam logic [1:0] MODE_INTER = 2'd0;
	localparam logic [1:0] MODE_UNION = 2'd1;
	localparam logic [1:0] MODE_DIFF  = 2'd2;

	typedef struct packed {
		logic [1:0] mode;  // intersection, union or x minus y
		logic       swap;  // x is list B, y is list A
		logic       neg;   // result denotes a complement
	} run_cmd_t;

	typedef struct packed {
		logic idle;    // walker can take a new run, loads allowed
		logic finish;  // run closes this cycle: clear counts and overflow
	} walk_stat_t;

	function automatic run_cmd_t decode_run(input logic op, input logic na, input logic nb);
		run_cmd_t c;
		c.swap = 1'b0;
		c.neg  = (op != OP_AND);
		if (op == OP_AND) begin
			case ({na, nb})
				2'b00:   c.mode = MODE_INTER;
				2'b01:   c.mode = MODE_DIFF;
				2'b10: begin
					c.mode = MODE_DIFF;
					c.swap = 1'b1;
				end
				default: begin
					c.mode = MODE_UNION;
					c.neg  = 1'b1;
				end
			endcase
		end else begin
			case ({na, nb})
				2'b00: begin
					c.mode = MODE_UNION;
					c.neg  = 1'b0;
				end
				2'b01: begin
					c.mode = MODE_DIFF;
					c.swap = 1'b1;
				end
				2'b10:   c.mode = MODE_DIFF;
				default: c.mode = MODE_INTER;
			endcase
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sdsm_in_if.sv =====
// Interface: input item channel (load or run commands).
`default_nettype none
interface sdsm_in_if;
	import sdsm_pkg::*;

	logic            valid;
	logic            ready;
	logic [1:0]      kind;
	logic [ID_W-1:0] doc_id;

	modport source (output valid, kind, doc_id, input ready);
	modport sink   (input valid, kind, doc_id, output ready);
endinterface
`default_nettype wire

// ===== rtl/sdsm_out_if.sv =====
// Interface: result item channel.
`default_nettype none
interface sdsm_out_if;
	import sdsm_pkg::*;

	logic            valid;
	logic            ready;
	logic [ID_W-1:0] result_id;
	logic            result_negated;
	logic            is_empty;
	logic            overflow;
	logic            last;

	modport source (output valid, result_id, result_negated, is_empty, overflow, last,
		input ready);
	modport sink   (input valid, result_id, result_negated, is_empty, overflow, last,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/sdsm_list_mem.sv =====
// Module: one id list store, single write port, single registered read port.
`default_nettype none
module sdsm_list_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int W     = 31
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data
);
	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

// ===== rtl/sdsm_walk.sv =====
// Module: two-pointer merge sequencer with one shared comparator and a result register.
`default_nettype none
module sdsm_walk #(
	parameter int AW = 5,
	parameter int CW = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  sdsm_pkg::run_cmd_t       cmd,
	input  logic [CW-1:0]            count_a,
	input  logic [CW-1:0]            count_b,
	input  logic                     overflow,
	input  logic [sdsm_pkg::ID_W-1:0] rd_a,
	input  logic [sdsm_pkg::ID_W-1:0] rd_b,
	output logic [AW-1:0]            addr_a,
	output logic [AW-1:0]            addr_b,
	output sdsm_pkg::walk_stat_t     stat,
	sdsm_out_if.source               results
);
	import sdsm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_FETCH  = 4'b0010,
		ST_CMP    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t          state_q;
	run_cmd_t        cmd_q;
	logic [CW-1:0]   i_q, j_q;
	logic            pend_valid_q;
	logic [ID_W-1:0] pend_id_q;

	logic            out_valid_q;
	logic [ID_W-1:0] out_id_q;
	logic            out_neg_q, out_empty_q, out_ovf_q, out_last_q;

	logic [CW-1:0]   nx, ny;
	logic [ID_W-1:0] xd, yd;
	logic            have_x, have_y, x_lt, x_eq;
	logic            emit, adv_i, adv_j, done;
	logic [ID_W-1:0] emit_id;
	logic            out_free, stall, step, finish;

	// x/y are A/B, or B/A for the reversed difference
	assign nx = cmd_q.swap ? count_b : count_a;
	assign ny = cmd_q.swap ? count_a : count_b;
	assign xd = cmd_q.swap ? rd_b : rd_a;
	assign yd = cmd_q.swap ? rd_a : rd_b;

	assign addr_a = cmd_q.swap ? j_q[AW-1:0] : i_q[AW-1:0];
	assign addr_b = cmd_q.swap ? i_q[AW-1:0] : j_q[AW-1:0];

	assign have_x = (i_q < nx);
	assign have_y = (j_q < ny);
	// the shared compare unit
	assign x_lt   = (xd < yd);
	assign x_eq   = (xd == yd);

	always_comb begin
		emit    = 1'b0;
		emit_id = xd;
		adv_i   = 1'b0;
		adv_j   = 1'b0;
		done    = 1'b0;
		if (have_x && have_y) begin
			if (x_lt) begin
				emit  = (cmd_q.mode != MODE_INTER);
				adv_i = 1'b1;
			end else if (x_eq) begin
				emit  = (cmd_q.mode != MODE_DIFF);
				adv_i = 1'b1;
				adv_j = 1'b1;
			end else begin
				emit    = (cmd_q.mode == MODE_UNION);
				emit_id = yd;
				adv_j   = 1'b1;
			end
		end else if (have_x && (cmd_q.mode != MODE_INTER)) begin
			emit  = 1'b1;
			adv_i = 1'b1;
		end else if (have_y && (cmd_q.mode == MODE_UNION)) begin
			emit    = 1'b1;
			emit_id = yd;
			adv_j   = 1'b1;
		end else begin
			done = 1'b1;
		end
	end

	assign out_free = !out_valid_q || results.ready;
	// a new id pushes the held one out, so it needs a free result slot
	assign stall    = emit && pend_valid_q && !out_free;
	assign step     = (state_q == ST_CMP) && !stall;
	assign finish   = (state_q == ST_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (step) begin
						if (emit) begin
							pend_valid_q <= 1'b1;
						end
						if (emit && pend_valid_q) begin
							out_valid_q <= 1'b1;
						end
						state_q <= done ? ST_FINISH : ST_FETCH;
					end
				end
				ST_FINISH: begin
					if (finish) begin
						out_valid_q  <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
			i_q   <= '0;
			j_q   <= '0;
		end
		if (step) begin
			if (adv_i) begin
				i_q <= i_q + 1'b1;
			end
			if (adv_j) begin
				j_q <= j_q + 1'b1;
			end
			if (emit) begin
				pend_id_q <= emit_id;
			end
			if (emit && pend_valid_q) begin
				out_id_q    <= pend_id_q;
				out_neg_q   <= cmd_q.neg;
				out_empty_q <= 1'b0;
				out_ovf_q   <= overflow;
				out_last_q  <= 1'b0;
			end
		end
		if (finish) begin
			out_id_q    <= pend_valid_q ? pend_id_q : '0;
			out_neg_q   <= cmd_q.neg;
			out_empty_q <= !pend_valid_q;
			out_ovf_q   <= overflow;
			out_last_q  <= 1'b1;
		end
	end

	assign stat.idle   = (state_q == ST_IDLE);
	assign stat.finish = finish;

	assign results.valid          = out_valid_q;
	assign results.result_id      = out_id_q;
	assign results.result_negated = out_neg_q;
	assign results.is_empty       = out_empty_q;
	assign results.overflow       = out_ovf_q;
	assign results.last           = out_last_q;
endmodule
`default_nettype wire

// ===== rtl/sorted_docid_set_merge.sv =====
// Top level: sorted doc-id list merge (intersection, union, difference with negation).
// Loads: one per cycle while idle, no result; the id is written in the same cycle.
// Run: each two-pointer step reads, then compares; up to ca+cb advancing steps plus
//   a last step that finds both lists spent, then a close step.
// Throughput is set by the single registered read port per list and the shared comparator.
// Reset clears counts, overflow flag, config and the sequencer; list contents stay unknown.
`default_nettype none
module sorted_docid_set_merge #(
	parameter int LIST_DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sdsm_in_if.sink                         items,
	sdsm_out_if.source                      results,
	input  logic                            cfg_wr_en,
	input  logic [sdsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sdsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sdsm_pkg::*;

	// address width for the stores, count width holds the full depth
	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

	// configuration registers
	logic op_q, neg_a_q, neg_b_q;

	// list fill state
	logic [CW-1:0] count_a_q, count_b_q;
	logic          ovf_q;

	logic            in_xfer;
	logic            load_a, load_b, run;
	logic [AW-1:0]   addr_a, addr_b;
	logic [ID_W-1:0] rd_a, rd_b;
	walk_stat_t      stat;
	run_cmd_t        cmd;

	// items are taken only while the walker is idle
	assign items.ready = stat.idle;
	assign in_xfer     = items.valid && items.ready;
	assign load_a      = in_xfer && (items.kind == KIND_LOAD_A);
	assign load_b      = in_xfer && (items.kind == KIND_LOAD_B);
	assign run         = in_xfer && (items.kind == KIND_RUN);
	// the unused kind code falls through with no effect

	assign cmd = decode_run(op_q, neg_a_q, neg_b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= 1'b0;
			neg_a_q <= 1'b0;
			neg_b_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_OPERATION:  op_q    <= cfg_wdata[0];
				CFG_FIRST_NEG:  neg_a_q <= cfg_wdata[0];
				CFG_SECOND_NEG: neg_b_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// counts and the overflow flag; a run closes by clearing all three
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= '0;
			count_b_q <= '0;
			ovf_q     <= 1'b0;
		end else if (stat.finish) begin
			count_a_q <= '0;
			count_b_q <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (load_a) begin
				if (count_a_q < FULL) begin
					count_a_q <= count_a_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (load_b) begin
				if (count_b_q < FULL) begin
					count_b_q <= count_b_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	sdsm_list_mem #(
		.DEPTH (LIST_DEPTH),
		.AW    (AW),
		.W     (ID_W)
	) u_list_a (
		.clk     (clk),
		.wr_en   (load_a && (count_a_q < FULL)),
		.wr_addr (count_a_q[AW-1:0]),
		.wr_data (items.doc_id),
		.rd_addr (addr_a),
		.rd_data (rd_a)
	);

	sdsm_list_mem #(
		.DEPTH (LIST_DEPTH),
		.AW    (AW),
		.W     (ID_W)
	) u_list_b (
		.clk     (clk),
		.wr_en   (load_b && (count_b_q < FULL)),
		.wr_addr (count_b_q[AW-1:0]),
		.wr_data (items.doc_id),
		.rd_addr (addr_b),
		.rd_data (rd_b)
	);

	// sequencer: holds one found id back so the final one can be marked last
	sdsm_walk #(
		.AW (AW),
		.CW (CW)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (run),
		.cmd      (cmd),
		.count_a  (count_a_q),
		.count_b  (count_b_q),
		.overflow (ovf_q),
		.rd_a     (rd_a),
		.rd_b     (rd_b),
		.addr_a   (addr_a),
		.addr_b   (addr_b),
		.stat     (stat),
		.results  (results)
	);
endmodule
`default_nettype wire

// ===== rtl/sdsm_checker.sv =====
// Checker: port-level properties of the doc-id set merge, bound to the top level.
`default_nettype none
module sdsm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [1:0]                in_kind,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [sdsm_pkg::ID_W-1:0] out_id,
	input logic                      out_empty,
	input logic                      out_last
);
	import sdsm_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(out_last))
		else $error("stalled result changed");

	// empty marker only on the single closing item
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_empty |-> out_last)
		else $error("empty result not marked last");

	// a run transfer makes the block busy
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_kind == KIND_RUN) |=> !in_ready)
		else $error("input taken right after a run");

	// while a non-final result is offered the run is still going
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input ready before run finished");
endmodule

bind sorted_docid_set_merge sdsm_checker u_sdsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_kind   (items.kind),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_id    (results.result_id),
	.out_empty (results.is_empty),
	.out_last  (results.last)
);
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the sorted doc-id set merge: random loads and runs checked against a scoreboard.
`timescale 1ns / 100ps
module tb;
	import sdsm_pkg::*;

	// kind 3 has no meaning in the block: it must be swallowed without effect
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic       OP_OR       = 1'b1;
	localparam int         DEPTH       = 32;
	localparam logic [ID_W-1:0] MAX_ID = 31'h7FFF_FFFF;
	// worst walk covers two full lists; leave a margin before touching config
	localparam int SETTLE_CYCLES = 2 * (2 * DEPTH) + 16;
	localparam int LONG_HOLD     = 300;

	typedef logic [ID_W-1:0] id_q_t[$];

	typedef struct {
		logic [ID_W-1:0] id;
		logic            negated;
		logic            empty_set;
		logic            overflow;
		logic            last;
	} merged_item_t;

	// Tracks both lists and the config, and queues the merged ids each run must produce.
	class docid_merge_board;
		logic [ID_W-1:0] store_a[DEPTH];
		logic [ID_W-1:0] store_b[DEPTH];
		int unsigned     cnt_a, cnt_b;
		logic            ovf_seen;
		logic            op, neg_a, neg_b;
		merged_item_t    merged_due[$];
		int unsigned     mismatches;

		function new();
			cnt_a = 0;
			cnt_b = 0;
			ovf_seen = 1'b0;
			op = OP_AND;
			neg_a = 1'b0;
			neg_b = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic val);
			case (idx)
				CFG_OPERATION:  op = val;
				CFG_FIRST_NEG:  neg_a = val;
				CFG_SECOND_NEG: neg_b = val;
				default: ;
			endcase
		endfunction

		function int unsigned due();
			return merged_due.size();
		endfunction

		// two-pointer walk over x and y; ties go to x
		function void walk_lists(logic [1:0] mode, id_q_t x, id_q_t y, ref id_q_t merged);
			int unsigned i, j;
			i = 0;
			j = 0;
			while (i < x.size() && j < y.size()) begin
				if (x[i] < y[j]) begin
					if (mode != MODE_INTER) merged.insert(merged.size(), x[i]);
					i++;
				end else if (x[i] > y[j]) begin
					if (mode == MODE_UNION) merged.insert(merged.size(), y[j]);
					j++;
				end else begin
					if (mode != MODE_DIFF) merged.insert(merged.size(), x[i]);
					i++;
					j++;
				end
			end
			if (mode != MODE_INTER)
				while (i < x.size()) merged.insert(merged.size(), x[i++]);
			if (mode == MODE_UNION)
				while (j < y.size()) merged.insert(merged.size(), y[j++]);
		endfunction

		function void run_merge();
			id_q_t        qa, qb, merged;
			logic [1:0]   mode;
			logic         swap, neg;
			merged_item_t it;
			for (int k = 0; k < cnt_a; k++) qa.insert(qa.size(), store_a[k]);
			for (int k = 0; k < cnt_b; k++) qb.insert(qb.size(), store_b[k]);
			swap = 1'b0;
			neg = 1'b0;
			if (op == OP_AND) begin
				case ({neg_a, neg_b})
					2'b00: mode = MODE_INTER;
					2'b01: mode = MODE_DIFF;
					2'b10: begin
						mode = MODE_DIFF;
						swap = 1'b1;
					end
					default: begin
						mode = MODE_UNION;
						neg = 1'b1;
					end
				endcase
			end else begin
				neg = 1'b1;
				case ({neg_a, neg_b})
					2'b00: begin
						mode = MODE_UNION;
						neg = 1'b0;
					end
					2'b01: begin
						mode = MODE_DIFF;
						swap = 1'b1;
					end
					2'b10: mode = MODE_DIFF;
					default: mode = MODE_INTER;
				endcase
			end
			if (swap) walk_lists(mode, qb, qa, merged);
			else walk_lists(mode, qa, qb, merged);
			if (merged.size() == 0) begin
				it = '{id: '0, negated: neg, empty_set: 1'b1, overflow: ovf_seen, last: 1'b1};
				merged_due.insert(merged_due.size(), it);
			end else begin
				foreach (merged[k]) begin
					it = '{id: merged[k], negated: neg, empty_set: 1'b0, overflow: ovf_seen,
						last: (k == merged.size() - 1)};
					merged_due.insert(merged_due.size(), it);
				end
			end
			cnt_a = 0;
			cnt_b = 0;
			ovf_seen = 1'b0;
		endfunction

		function void accept_item(logic [1:0] kind, logic [ID_W-1:0] id);
			case (kind)
				KIND_LOAD_A:
					if (cnt_a < DEPTH) store_a[cnt_a++] = id;
					else ovf_seen = 1'b1;
				KIND_LOAD_B:
					if (cnt_b < DEPTH) store_b[cnt_b++] = id;
					else ovf_seen = 1'b1;
				KIND_RUN: run_merge();
				default: ;
			endcase
		endfunction

		function void field_ok(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [ID_W-1:0] id, logic negated, logic empty_set,
				logic overflow, logic last);
			merged_item_t want;
			if (merged_due.size() == 0) begin
				mismatches++;
				$display("%0t: result id %0h with nothing pending", $time, id);
				return;
			end
			want = merged_due.pop_front();
			field_ok("result_id", want.id, id);
			field_ok("result_negated", want.negated, negated);
			field_ok("is_empty", want.empty_set, empty_set);
			field_ok("overflow", want.overflow, overflow);
			field_ok("last", want.last, last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	sdsm_in_if  item_ch ();
	sdsm_out_if result_ch ();

	docid_merge_board board = new();
	int unsigned items_sent = 0;    // transfers of load/run items, kind 3 not counted
	int unsigned results_seen = 0;  // result transfers so far, drives the long hold-off
	int unsigned hold_asked = 0;    // long hold-offs asked for by the stimulus

	sorted_docid_set_merge #(.LIST_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (item_ch.sink),
		.results   (result_ch.source),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitor: every transfer on either channel is seen at the rising edge, before the
	// block's flops update. Input transfers feed the predictor, results get checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				board.accept_item(item_ch.kind, item_ch.doc_id);
			if (result_ch.valid && result_ch.ready) begin
				board.check_result(result_ch.result_id, result_ch.result_negated,
					result_ch.is_empty, result_ch.overflow, result_ch.last);
				results_seen++;
			end
		end
	end

	// mostly back to back, sometimes a short gap, rarely a long pause
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ID_W-1:0] rand_id();
		return ID_W'($urandom());
	endfunction

	// Called and returns at a falling edge; valid stays high so the next item can follow
	// without a bubble. Exactly one assignment to valid per step.
	task automatic send_item(input logic [1:0] kind, input logic [ID_W-1:0] id);
		int unsigned gap;
		gap = pick_gap();
		repeat (gap) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid  <= 1'b1;
		item_ch.kind   <= kind;
		item_ch.doc_id <= id;
		if (kind != KIND_UNUSED) items_sent++;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid, drain all pending results, then give the walker time to close its run.
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (board.due() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// only called while the block is idle
	task automatic write_config(input logic op, input logic na, input logic nb);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_OPERATION;
		cfg_wdata <= op;
		@(negedge clk);
		cfg_index <= CFG_FIRST_NEG;
		cfg_wdata <= na;
		@(negedge clk);
		cfg_index <= CFG_SECOND_NEG;
		cfg_wdata <= nb;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		board.set_reg(CFG_OPERATION, op);
		board.set_reg(CFG_FIRST_NEG, na);
		board.set_reg(CFG_SECOND_NEG, nb);
	endtask

	function automatic int unsigned pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) return $urandom_range(20, DEPTH);
		if (r < 14) return $urandom_range(DEPTH + 1, DEPTH + 3);
		return $urandom_range(0, 5);
	endfunction

	// small steps from a common base, so the two lists share many ids
	task automatic fill_ids(ref id_q_t q, input int unsigned n, input logic [ID_W-1:0] start);
		logic [ID_W-1:0] cur;
		cur = start;
		repeat (n) begin
			q.insert(q.size(), cur);
			cur = cur + ID_W'($urandom_range(1, 4));
		end
	endtask

	// One sequence: usually two ascending lists loaded interleaved, then a run.
	// Now and then noise, a non-ascending list, or no run so loads pile up.
	task automatic send_sequence(input bit force_full);
		int unsigned     r, len_a, len_b, ia, ib;
		logic [ID_W-1:0] base, tmp;
		id_q_t           seq_a, seq_b;
		r = $urandom_range(0, 99);
		if (!force_full && r < 10) begin
			repeat ($urandom_range(1, 4))
				send_item(2'($urandom_range(0, 3)), rand_id());
			return;
		end
		len_a = force_full ? $urandom_range(DEPTH + 1, DEPTH + 3) : pick_len();
		len_b = pick_len();
		r = $urandom_range(0, 99);
		if (r < 10) base = '0;
		else if (r < 20) base = MAX_ID - ID_W'(150);
		else base = ID_W'($urandom_range(0, MAX_ID - 150));
		fill_ids(seq_a, len_a, base);
		fill_ids(seq_b, len_b, base + ID_W'($urandom_range(0, 3)));
		if (len_a > 1 && $urandom_range(0, 99) < 8) begin
			tmp = seq_a[0];
			seq_a[0] = seq_a[len_a - 1];
			seq_a[len_a - 1] = tmp;
		end
		ia = 0;
		ib = 0;
		while (ia < len_a || ib < len_b) begin
			if (ib >= len_b || (ia < len_a && $urandom_range(0, 1) == 1))
				send_item(KIND_LOAD_A, seq_a[ia++]);
			else
				send_item(KIND_LOAD_B, seq_b[ib++]);
		end
		if ($urandom_range(0, 99) < 5) send_item(KIND_UNUSED, rand_id());
		if (force_full || $urandom_range(0, 99) >= 6) send_item(KIND_RUN, rand_id());
	endtask

	// Result side: random stalls, calm stretches, and a long hold-off on request or every
	// so often, so the walker backs up and the item channel stalls while items keep coming.
	initial begin : result_sink
		int unsigned stall_left, calm_left, hold_mark, hold_taken;
		result_ch.ready = 1'b0;
		stall_left = 0;
		calm_left = 0;
		hold_mark = 30;
		hold_taken = 0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (hold_asked != hold_taken || results_seen >= hold_mark) begin
				result_ch.ready <= 1'b0;
				stall_left = LONG_HOLD - 1;
				if (results_seen >= hold_mark) hold_mark += 150;
				hold_taken = hold_asked;
			end else begin
				result_ch.ready <= 1'b1;
				if (calm_left != 0) calm_left--;
				else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(50, 200);
				else if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
			end
		end
	end

	initial begin : stimulus
		int unsigned combo, phase_start, p;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_LOAD_A;
		item_ch.doc_id = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_OPERATION;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset config (plain AND).
		// run with both lists empty: single empty item
		send_item(KIND_RUN, '0);
		// extremes of the id range, shared top end
		send_item(KIND_LOAD_A, '0);
		send_item(KIND_LOAD_A, 31'd7);
		send_item(KIND_LOAD_A, MAX_ID);
		send_item(KIND_LOAD_B, 31'd7);
		send_item(KIND_LOAD_B, 31'h2AAA_AAAA);
		send_item(KIND_LOAD_B, MAX_ID);
		send_item(KIND_RUN, 31'h5555_5555);
		// unknown kind: no result, no state change
		send_item(KIND_UNUSED, MAX_ID);
		// list A out of order
		send_item(KIND_LOAD_A, 31'd9);
		send_item(KIND_LOAD_A, 31'd3);
		send_item(KIND_LOAD_B, 31'd3);
		send_item(KIND_RUN, MAX_ID);
		// long result hold-off: the walker backs up and later items wait at the input
		hold_asked++;
		for (int k = 0; k < 4; k++) send_item(KIND_LOAD_A, ID_W'(10 + k));
		for (int k = 0; k < 4; k++) send_item(KIND_LOAD_B, ID_W'(10 + k));
		send_item(KIND_RUN, '0);
		send_item(KIND_LOAD_A, 31'd5);
		send_item(KIND_LOAD_A, 31'd6);
		send_item(KIND_RUN, '0);
		settle();

		// OR with A negated: A minus B, negated result
		write_config(OP_OR, 1'b1, 1'b0);
		send_item(KIND_LOAD_A, '0);
		send_item(KIND_LOAD_A, MAX_ID);
		send_item(KIND_LOAD_B, MAX_ID);
		send_item(KIND_RUN, '0);
		settle();

		// AND with both negated on empty lists: empty, negated
		write_config(OP_AND, 1'b1, 1'b1);
		send_item(KIND_RUN, MAX_ID);
		settle();

		// Random phases: one for each of the eight operator/negation settings.
		for (p = 0; p < 8; p++) begin
			combo = p;
			write_config(combo[2], combo[1], combo[0]);
			phase_start = items_sent;
			// in the first phase, the first sequence overfills list A
			send_sequence(p == 0);
			while (items_sent - phase_start < 4) send_sequence(1'b0);
			settle();
		end

		if (board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
